>>> src/assert_macros.svh
// Assertion macros used by the capsule routing top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/cdr_pkg.sv
// Types, constants and tables of the capsule routing block.
package cdr_pkg;

  localparam int MAX_CAPS_DEF = 8;
  localparam int MAX_DIM_DEF  = 8;
  localparam int MAX_IN_DEF   = 64;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 7;

  localparam logic [CFG_IW-1:0] CFG_CAPS_USED     = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DIM_USED      = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IN_LEN_USED   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_ROUTING_ITERS = 2'd3;

  localparam logic OP_WEIGHT  = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  localparam int DIV_W = 64;

  localparam logic signed [32:0] LOG2E_Q16 = 33'sd94548;

  typedef struct packed {
    logic              operation;
    logic [2:0]        out_capsule;
    logic [5:0]        in_index;
    logic [2:0]        out_component;
    logic signed [15:0] value;
    logic              last_element;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         capsule_index;
    logic [2:0]         component_index;
    logic signed [15:0] component_value;
    logic [14:0]        capsule_length;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Q.30 roots 2^(2^b/256)
  localparam logic [63:0] TWO_ROOTS [8] = '{
    64'd1076653033, 64'd1079572136, 64'd1085434103, 64'd1097253709,
    64'd1121280436, 64'd1170923763, 64'd1276901416, 64'd1518500250
  };

  typedef logic [16:0] p_tab_t [256];

  // 2^(i/256) in Q.16, built from the roots by rounded products
  function automatic p_tab_t build_p_tab();
    p_tab_t      t;
    logic [63:0] acc;
    for (int idx = 0; idx < 256; idx++) begin
      acc = 64'd1 << 30;
      for (int b = 7; b >= 0; b--) begin
        if (((idx >> b) & 1) != 0) begin
          acc = (acc * TWO_ROOTS[b] + (64'd1 << 29)) >> 30;
        end
      end
      t[idx] = 17'((acc + (64'd1 << 13)) >> 14);
    end
    return t;
  endfunction

  localparam p_tab_t P_TAB = build_p_tab();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/cdr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module cdr_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdr_pkg::div_req_t       req,
  output cdr_pkg::unit_sts_t      sts,
  output logic [cdr_pkg::DIV_W-1:0] quo
);
  import cdr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic [DIV_W:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

>>> src/cdr_isqrt.sv
// Floor square root of a 64-bit value, two radicand bits per cycle.
module cdr_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  cdr_pkg::sqrt_req_t  req,
  output cdr_pkg::unit_sts_t  sts,
  output logic [31:0]         root
);
  import cdr_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    trial    = r_r + bit_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      x_nxt    = req.rad;
      r_nxt    = '0;
      bit_nxt  = 64'd1 << 62;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = r_r[31:0];

endmodule

>>> src/capsule_dynamic_routing.sv
// Capsule layer with routing by agreement: top level, sequencer and memories.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_item_t (weight or input element)
//  out_    | output    | out_valid/out_stall | out_item_t (one squashed component)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// Weight and element items are taken one per cycle while in_stall is low. The last element
// starts a run that computes the predictions by multiply-accumulate, then in each round
// squashes every capsule, most of it in the bit-serial divider, and between rounds updates
// the couplings. in_stall is high for the whole run; results leave through an output
// register that out_stall holds.
// Synchronous reset clears control state, presets config; memories stay as written.
module capsule_dynamic_routing #(
  parameter int MAX_CAPS = cdr_pkg::MAX_CAPS_DEF,
  parameter int MAX_DIM  = cdr_pkg::MAX_DIM_DEF,
  parameter int MAX_IN   = cdr_pkg::MAX_IN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cdr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cdr_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [cdr_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [cdr_pkg::CFG_DW-1:0]    cfg_data
);
  import cdr_pkg::*;
  `include "assert_macros.svh"

  localparam int CW   = (MAX_CAPS > 1) ? $clog2(MAX_CAPS) : 1;
  localparam int DW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int WDEP = MAX_CAPS * MAX_IN * MAX_DIM;
  localparam int PDEP = MAX_CAPS * MAX_DIM;
  localparam int WAW  = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int PAW  = (PDEP > 1) ? $clog2(PDEP) : 1;
  localparam int AW   = 33 + IW;
  localparam int AAW  = 49 + DW;

  typedef enum logic [27:0] {
    S_IDLE   = 28'h0000001,
    S_INIT   = 28'h0000002,
    S_INITW  = 28'h0000004,
    S_PRED   = 28'h0000008,
    S_PDRN   = 28'h0000010,
    S_SRD    = 28'h0000020,
    S_SMUL   = 28'h0000040,
    S_SABS   = 28'h0000080,
    S_SSQ    = 28'h0000100,
    S_SACC   = 28'h0000200,
    S_SQRTW  = 28'h0000400,
    S_VMUL   = 28'h0000800,
    S_VSTART = 28'h0001000,
    S_VDIVW  = 28'h0002000,
    S_LSTART = 28'h0004000,
    S_LDIVW  = 28'h0008000,
    S_ARD    = 28'h0010000,
    S_AMUL   = 28'h0020000,
    S_AACC   = 28'h0040000,
    S_ALOG   = 28'h0080000,
    S_MAX    = 28'h0100000,
    S_EXPD   = 28'h0200000,
    S_EXPM   = 28'h0400000,
    S_EXPE   = 28'h0800000,
    S_CSTART = 28'h1000000,
    S_CDIVW  = 28'h2000000,
    S_ORD    = 28'h4000000,
    S_OWAIT  = 28'h8000000
  } state_t;

  // configuration
  logic [3:0] caps_r, dim_r;
  logic [6:0] inlen_r;
  logic [2:0] iters_r;

  // sequencer
  state_t  state_r, state_nxt;
  logic [CW-1:0] j_r, j_nxt, jl_r, jl_nxt;
  logic [DW-1:0] k_r, k_nxt, kl_r, kl_nxt;
  logic [IW-1:0] i_r, i_nxt, il_r, il_nxt;
  logic [2:0]    nr_r, nr_nxt, round_r, round_nxt;
  logic          pass2_r, pass2_nxt;
  logic          rd_v_r, rd_v_nxt, mul_v_r;

  // datapath
  logic signed [AW-1:0]  acc_r, acc_nxt;
  logic signed [AAW-1:0] a_r, a_nxt;
  logic [63:0]           nsq_r, nsq_nxt;
  logic [31:0]           nrm_r, nrm_nxt;
  logic [31:0]           m_r, m_nxt;
  logic                  sneg_r, sneg_nxt;
  logic signed [31:0]    mx_r, mx_nxt;
  logic signed [32:0]    d_r, d_nxt;
  logic [21:0]           sum_r, sum_nxt;
  logic signed [32:0]    mul_a, mul_b;
  logic signed [65:0]    mul_r;

  // per-capsule values
  logic [16:0]        coup_r  [MAX_CAPS];
  logic signed [31:0] logit_r [MAX_CAPS];
  logic [16:0]        e_r     [MAX_CAPS];
  logic [14:0]        len_r   [MAX_CAPS];
  logic               coup_all_we, coup_we, logit_clr, logit_we, e_we, len_we;
  logic [16:0]        coup_wdata, e_wdata;
  logic signed [31:0] logit_wdata;
  logic [14:0]        len_wdata;

  // memories
  logic signed [15:0] w_mem    [WDEP];
  logic signed [15:0] x_mem    [MAX_IN];
  logic signed [31:0] pred_mem [PDEP];
  logic signed [15:0] sq_mem   [PDEP];
  logic signed [15:0] w_q, x_q, sq_q;
  logic signed [31:0] pred_q;
  logic               w_we, x_we, pred_we, pred_re, sq_we, sq_re, pred_go;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic [IW-1:0]      x_waddr;
  logic [PAW-1:0]     p_addr;
  logic signed [31:0] pred_wdata;
  logic signed [15:0] sq_wdata;

  // units
  div_req_t      div_req;
  unit_sts_t     div_sts;
  logic [63:0]   div_quo;
  sqrt_req_t     sqrt_req;
  unit_sts_t     sqrt_sts;
  logic [31:0]   sqrt_root;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // helpers
  logic              in_acc;
  int                nc_i, nd_i, nl_i, nr_i;
  logic signed [32:0] s_w, sabs_w;
  logic [64:0]       nsq_sum, den_sum;
  logic [63:0]       nsq_sat, den_w, q_w;
  logic [14:0]       qv_w, lq_w;
  logic signed [63:0] acc_ext, a_ext, pw_ext, lg_ext;
  logic signed [31:0] ag_w;
  logic signed [34:0] t_w;
  logic signed [18:0] p_w, np_w;
  logic [16:0]       e_w;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r  <= 4'd8;
      dim_r   <= 4'd8;
      inlen_r <= 7'd64;
      iters_r <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPS_USED:     caps_r  <= cfg_data[3:0];
        CFG_DIM_USED:      dim_r   <= cfg_data[3:0];
        CFG_IN_LEN_USED:   inlen_r <= cfg_data[6:0];
        CFG_ROUTING_ITERS: iters_r <= cfg_data[2:0];
      endcase
    end
  end

  // registers of 0 act as 1, above the maximum as the maximum
  always_comb begin
    nc_i = (caps_r == 4'd0) ? 1 : ((int'(caps_r) > MAX_CAPS) ? MAX_CAPS : int'(caps_r));
    nd_i = (dim_r == 4'd0) ? 1 : ((int'(dim_r) > MAX_DIM) ? MAX_DIM : int'(dim_r));
    nl_i = (inlen_r == 7'd0) ? 1 : ((int'(inlen_r) > MAX_IN) ? MAX_IN : int'(inlen_r));
    nr_i = (iters_r == 3'd0) ? 1 : int'(iters_r);
  end

  assign w_we    = in_acc && (in_data.operation == OP_WEIGHT) &&
                   (int'(in_data.out_capsule) < MAX_CAPS) &&
                   (int'(in_data.in_index) < MAX_IN) &&
                   (int'(in_data.out_component) < MAX_DIM);
  assign x_we    = in_acc && (in_data.operation == OP_ELEMENT) &&
                   (int'(in_data.in_index) < MAX_IN);
  assign w_waddr = WAW'(int'(in_data.out_capsule) * MAX_IN * MAX_DIM +
                        int'(in_data.in_index) * MAX_DIM + int'(in_data.out_component));
  assign x_waddr = IW'(in_data.in_index);
  assign w_raddr = WAW'(int'(j_r) * MAX_IN * MAX_DIM + int'(i_r) * MAX_DIM + int'(k_r));
  assign p_addr  = PAW'(int'(j_r) * MAX_DIM + int'(k_r));
  assign pred_go = (state_r == S_PRED);
  assign pred_re = (state_r == S_SRD) || (state_r == S_ARD);
  assign sq_re   = (state_r == S_ARD) || (state_r == S_ORD);

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= in_data.value;
    if (pred_go) w_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_waddr] <= in_data.value;
    if (pred_go) x_q <= x_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[p_addr] <= pred_wdata;
    if (pred_re) pred_q <= pred_mem[p_addr];
  end

  always_ff @(posedge clk) begin
    if (sq_we) sq_mem[p_addr] <= sq_wdata;
    if (sq_re) sq_q <= sq_mem[p_addr];
  end

  // shared multiplier, operands chosen by the step in progress
  always_comb begin
    unique case (state_r)
      S_SMUL: begin
        mul_a = signed'({16'b0, coup_r[j_r]});
        mul_b = 33'(pred_q);
      end
      S_SSQ: begin
        mul_a = signed'({1'b0, m_r});
        mul_b = signed'({1'b0, m_r});
      end
      S_VMUL: begin
        mul_a = signed'({1'b0, m_r});
        mul_b = signed'({1'b0, nrm_r});
      end
      S_AMUL: begin
        mul_a = 33'(pred_q);
        mul_b = 33'(sq_q);
      end
      S_EXPM: begin
        mul_a = d_r;
        mul_b = LOG2E_Q16;
      end
      default: begin
        mul_a = 33'(x_q);
        mul_b = 33'(w_q);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  cdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  cdr_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .sts   (sqrt_sts),
    .root  (sqrt_root)
  );

  // arithmetic around the sequencer
  always_comb begin
    s_w     = mul_r[48:16];
    sabs_w  = s_w[32] ? -s_w : s_w;
    nsq_sum = {1'b0, nsq_r} + {1'b0, mul_r[63:0]};
    nsq_sat = nsq_sum[64] ? '1 : nsq_sum[63:0];
    den_sum = {1'b0, nsq_r} + (65'd1 << 32);
    den_w   = den_sum[64] ? '1 : den_sum[63:0];
    q_w     = div_quo >> 1;
    qv_w    = (q_w > 64'd32767) ? 15'h7fff : q_w[14:0];
    lq_w    = (div_quo > 64'd32767) ? 15'h7fff : div_quo[14:0];
    acc_ext = 64'(acc_r);
    pw_ext  = (acc_ext + 64'sd128) >>> 8;
    a_ext   = 64'(a_r);
    ag_w    = sat32(a_ext >>> 15);
    lg_ext  = 64'(logit_r[j_r]) + 64'(ag_w);
    t_w     = mul_r[50:16];
    p_w     = t_w[34:16];
    np_w    = -p_w;
    e_w     = (np_w > 19'sd31) ? 17'd0 : (P_TAB[t_w[15:8]] >> np_w[4:0]);
  end

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    jl_nxt        = jl_r;
    k_nxt         = k_r;
    kl_nxt        = kl_r;
    i_nxt         = i_r;
    il_nxt        = il_r;
    nr_nxt        = nr_r;
    round_nxt     = round_r;
    pass2_nxt     = pass2_r;
    rd_v_nxt      = 1'b0;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    nsq_nxt       = nsq_r;
    nrm_nxt       = nrm_r;
    m_nxt         = m_r;
    sneg_nxt      = sneg_r;
    mx_nxt        = mx_r;
    d_nxt         = d_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pred_we       = 1'b0;
    pred_wdata    = sat32(pw_ext);
    sq_we         = 1'b0;
    sq_wdata      = sneg_r ? -signed'({1'b0, qv_w}) : signed'({1'b0, qv_w});
    coup_all_we   = 1'b0;
    coup_we       = 1'b0;
    coup_wdata    = div_quo[16:0];
    logit_clr     = 1'b0;
    logit_we      = 1'b0;
    logit_wdata   = sat32(lg_ext);
    e_we          = 1'b0;
    e_wdata       = e_w;
    len_we        = 1'b0;
    len_wdata     = lq_w;
    div_req       = '0;
    sqrt_req      = '0;
    sqrt_req.rad  = nsq_sat;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (mul_v_r) acc_nxt = acc_r + mul_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.operation == OP_ELEMENT) && in_data.last_element) begin
          jl_nxt    = CW'(nc_i - 1);
          kl_nxt    = DW'(nd_i - 1);
          il_nxt    = IW'(nl_i - 1);
          nr_nxt    = 3'(nr_i);
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        div_req.start = 1'b1;
        div_req.num   = 64'd65536;
        div_req.den   = 64'(jl_r) + 64'd1;
        logit_clr     = 1'b1;
        state_nxt     = S_INITW;
      end
      S_INITW: begin
        if (div_sts.done) begin
          coup_all_we = 1'b1;
          j_nxt       = '0;
          k_nxt       = '0;
          i_nxt       = '0;
          acc_nxt     = '0;
          state_nxt   = S_PRED;
        end
      end
      S_PRED: begin
        rd_v_nxt = 1'b1;
        if (i_r == il_r) begin
          i_nxt     = '0;
          state_nxt = S_PDRN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_PDRN: begin
        if (!rd_v_r && !mul_v_r) begin
          pred_we = 1'b1;
          acc_nxt = '0;
          if (k_r == kl_r) begin
            k_nxt = '0;
            if (j_r == jl_r) begin
              j_nxt     = '0;
              round_nxt = '0;
              pass2_nxt = 1'b0;
              nsq_nxt   = '0;
              state_nxt = S_SRD;
            end else begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_PRED;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_PRED;
          end
        end
      end
      S_SRD:  state_nxt = S_SMUL;
      S_SMUL: state_nxt = S_SABS;
      S_SABS: begin
        m_nxt     = sabs_w[31:0];
        sneg_nxt  = s_w[32];
        state_nxt = pass2_r ? S_VMUL : S_SSQ;
      end
      S_SSQ: state_nxt = S_SACC;
      S_SACC: begin
        nsq_nxt = nsq_sat;
        if (k_r == kl_r) begin
          sqrt_req.start = 1'b1;
          state_nxt      = S_SQRTW;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SQRTW: begin
        if (sqrt_sts.done) begin
          nrm_nxt   = sqrt_root;
          pass2_nxt = 1'b1;
          k_nxt     = '0;
          state_nxt = S_SRD;
        end
      end
      S_VMUL: state_nxt = S_VSTART;
      S_VSTART: begin
        div_req.start = 1'b1;
        div_req.num   = mul_r[63:0];
        div_req.den   = den_w >> 16;
        state_nxt     = S_VDIVW;
      end
      S_VDIVW: begin
        if (div_sts.done) begin
          sq_we = 1'b1;
          if (k_r == kl_r) begin
            state_nxt = S_LSTART;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_LSTART: begin
        div_req.start = 1'b1;
        div_req.num   = nsq_r;
        div_req.den   = den_w >> 15;
        state_nxt     = S_LDIVW;
      end
      S_LDIVW: begin
        if (div_sts.done) begin
          len_we    = 1'b1;
          k_nxt     = '0;
          pass2_nxt = 1'b0;
          nsq_nxt   = '0;
          if (j_r == jl_r) begin
            j_nxt = '0;
            if (4'(round_r) + 4'd1 < 4'(nr_r)) begin
              a_nxt     = '0;
              state_nxt = S_ARD;
            end else begin
              state_nxt = S_ORD;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_ARD:  state_nxt = S_AMUL;
      S_AMUL: state_nxt = S_AACC;
      S_AACC: begin
        a_nxt = a_r + mul_r[AAW-1:0];
        if (k_r == kl_r) begin
          state_nxt = S_ALOG;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_ALOG: begin
        logit_we = 1'b1;
        a_nxt    = '0;
        k_nxt    = '0;
        if (j_r == jl_r) begin
          j_nxt     = '0;
          state_nxt = S_MAX;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_MAX: begin
        if ((j_r == '0) || (logit_r[j_r] > mx_r)) mx_nxt = logit_r[j_r];
        if (j_r == jl_r) begin
          j_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_EXPD;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_EXPD: begin
        d_nxt     = 33'(logit_r[j_r]) - 33'(mx_r);
        state_nxt = S_EXPM;
      end
      S_EXPM: state_nxt = S_EXPE;
      S_EXPE: begin
        e_we    = 1'b1;
        sum_nxt = sum_r + 22'(e_w);
        if (j_r == jl_r) begin
          j_nxt     = '0;
          state_nxt = S_CSTART;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_EXPD;
        end
      end
      S_CSTART: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(e_r[j_r]) << 16;
        div_req.den   = 64'(sum_r);
        state_nxt     = S_CDIVW;
      end
      S_CDIVW: begin
        if (div_sts.done) begin
          coup_we = 1'b1;
          if (j_r == jl_r) begin
            j_nxt     = '0;
            k_nxt     = '0;
            round_nxt = round_r + 1'b1;
            state_nxt = S_SRD;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_CSTART;
          end
        end
      end
      S_ORD: state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.capsule_index   = 3'(j_r);
          out_data_nxt.component_index = 3'(k_r);
          out_data_nxt.component_value = sq_q;
          out_data_nxt.capsule_length  = len_r[j_r];
          out_data_nxt.last_result     = (j_r == jl_r) && (k_r == kl_r);
          if (k_r == kl_r) begin
            k_nxt = '0;
            if (j_r == jl_r) begin
              j_nxt     = '0;
              state_nxt = S_IDLE;
            end else begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_ORD;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      k_r         <= '0;
      i_r         <= '0;
      jl_r        <= '0;
      kl_r        <= '0;
      il_r        <= '0;
      nr_r        <= '0;
      round_r     <= '0;
      pass2_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      jl_r        <= jl_nxt;
      kl_r        <= kl_nxt;
      il_r        <= il_nxt;
      nr_r        <= nr_nxt;
      round_r     <= round_nxt;
      pass2_r     <= pass2_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
    acc_r      <= acc_nxt;
    a_r        <= a_nxt;
    nsq_r      <= nsq_nxt;
    nrm_r      <= nrm_nxt;
    m_r        <= m_nxt;
    sneg_r     <= sneg_nxt;
    mx_r       <= mx_nxt;
    d_r        <= d_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_CAPS; c++) begin
      if (coup_all_we) coup_r[c] <= coup_wdata;
      if (logit_clr) logit_r[c] <= '0;
    end
    if (coup_we) coup_r[j_r] <= coup_wdata;
    if (logit_we) logit_r[j_r] <= logit_wdata;
    if (e_we) e_r[j_r] <= e_wdata;
    if (len_we) len_r[j_r] <= len_wdata;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_div_overlap, clk, rst_n, div_req.start && div_sts.busy)
  `ASSERT_IMPL(a_idle_units, clk, rst_n, state_r == S_IDLE, !div_sts.busy && !sqrt_sts.busy)
  `ASSERT_IMPL(a_sqrt_done, clk, rst_n, sqrt_sts.done, state_r == S_SQRTW)
  `ASSERT_IMPL(a_out_load, clk, rst_n, $rose(out_valid_r), $past(state_r == S_OWAIT))

endmodule
